/* src/bfi_pkg.sv */
// Package for the bitcell-to-flux-interval converter.
// Holds widths, reset values, register codes and queue depths; no dependencies.
`default_nettype none
package bfi_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 256;

   localparam int TICKS_W   = 16;
   localparam int TRACK_W   = 15;
   localparam int BYTE_W    = 8;
   localparam int FLUX_W    = 16;
   localparam int ACC_W     = 32;
   localparam int FRAC_W    = 4;
   localparam int CELL_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam int BYTE_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH  = 4;

   localparam logic [TICKS_W-1:0] CELL_TICKS_RESET = 16'd4608;
   localparam logic [TRACK_W-1:0] TRACK_LEN_RESET  = 15'd6250;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LEN  = 1'b1;

   // result queue entry
   typedef struct packed {
      logic [FLUX_W-1:0] flux_interval;
      logic              last_of_byte;
   } rsp_type;

endpackage
`default_nettype wire

/* src/bitcell_to_flux_interval.sv */
// Bitcell-to-flux-interval converter, top level.
// A taken byte passes through the byte queue and the back end's bit register before its
// results reach the result queue. The back end walks one bit cell per cycle, stalling
// when a set bit meets a full result queue. Input and results decouple via queues.
// Reset: synchronous; clears counters, accumulator and queues, restores registers.
`default_nettype none
module bitcell_to_flux_interval
   import bfi_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic      [FLUX_W-1:0]    rsp_flux_interval,
   output logic                      rsp_last_of_byte,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);
   logic [TICKS_W-1:0] cell_ticks_ff;
   logic [TRACK_W-1:0] track_len_ff;
   logic               accept, take;
   logic               byte_empty, byte_pop;
   logic [BYTE_W-1:0]  byte_head;
   logic               rsp_full, rsp_push;
   rsp_type            rsp_in_data, rsp_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ticks_ff <= CELL_TICKS_RESET;
         track_len_ff  <= TRACK_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CELL_TICKS: cell_ticks_ff <= csr_data[TICKS_W-1:0];
            CSR_TRACK_LEN:  track_len_ff  <= csr_data[TRACK_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_push & ~req_full;

   bfi_front #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .track_len (track_len_ff),
      .take      (take)
   );

   bfi_fifo #(
      .WIDTH(BYTE_W),
      .DEPTH(BYTE_QUEUE_DEPTH)
   ) u_byte_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (req_data_byte),
      .full      (req_full),
      .pop       (byte_pop),
      .pop_data  (byte_head),
      .empty     (byte_empty)
   );

   bfi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cell_ticks (cell_ticks_ff),
      .byte_avail (~byte_empty),
      .byte_data  (byte_head),
      .byte_pop   (byte_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in_data)
   );

   bfi_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_flux_interval = rsp_head.flux_interval;
   assign rsp_last_of_byte  = rsp_head.last_of_byte;

endmodule
`default_nettype wire

/* src/bfi_fifo.sv */
// Small first-in first-out queue of registers.
// Used for the byte queue and the result queue; no package dependencies.
`default_nettype none
module bfi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/bfi_front.sv */
// Front end: track position and block offset bookkeeping.
// Decides per byte whether it is taken or dropped; uses bfi_pkg.
`default_nettype none
module bfi_front
   import bfi_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [TRACK_W-1:0] track_len,
   output logic                    take
);
   localparam int OFS_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

   logic [TRACK_W-1:0] pos_ff, pos_in;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   logic               past_end;

   assign past_end = (pos_ff >= track_len);

   always_comb begin
      pos_in = pos_ff;
      ofs_in = ofs_ff;
      take   = 1'b0;
      if (accept) begin
         ofs_in = (ofs_ff == OFS_W'(BLOCK_BYTES-1)) ? '0 : ofs_ff + 1'b1;
         if (past_end && ofs_ff != '0) begin
            // drop fill bytes up to the block boundary
            take = 1'b0;
         end else begin
            take   = 1'b1;
            pos_in = past_end ? TRACK_W'(1) : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ofs_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ofs_ff <= ofs_in;
      end
   end

endmodule
`default_nettype wire

/* src/bfi_back.sv */
// Back end: walks the eight bit cells of a byte, one per cycle unless a set bit meets a full result queue.
// Keeps the tick accumulator and emits flux intervals; uses bfi_pkg.
`default_nettype none
module bfi_back
   import bfi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TICKS_W-1:0] cell_ticks,
   input  wire logic               byte_avail,
   input  wire logic [BYTE_W-1:0]  byte_data,
   output logic                    byte_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output rsp_type                 rsp_data
);
   logic              busy_ff, busy_in;
   logic [BYTE_W-1:0] bits_ff, bits_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  sum;
   logic              stall, finish;

   assign sum   = acc_ff + ACC_W'(cell_ticks);
   assign stall = busy_ff & bits_ff[0] & rsp_full;

   assign rsp_data.flux_interval = sum[FRAC_W +: FLUX_W] - 1'b1;
   assign rsp_data.last_of_byte  = (bits_ff[BYTE_W-1:1] == '0);

   always_comb begin
      busy_in  = busy_ff;
      bits_in  = bits_ff;
      cell_in  = cell_ff;
      acc_in   = acc_ff;
      rsp_push = 1'b0;
      finish   = 1'b0;
      if (busy_ff && !stall) begin
         rsp_push = bits_ff[0];
         acc_in   = bits_ff[0] ? {{(ACC_W-FRAC_W){1'b0}}, sum[FRAC_W-1:0]} : sum;
         bits_in  = bits_ff >> 1;
         cell_in  = cell_ff + 1'b1;
         finish   = (cell_ff == CELL_W'(BYTE_W-1));
         if (finish) begin
            busy_in = 1'b0;
         end
      end
      byte_pop = byte_avail & (~busy_ff | finish);
      if (byte_pop) begin
         // load the next byte right behind the last cell
         busy_in = 1'b1;
         bits_in = byte_data;
         cell_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cell_ff <= '0;
         acc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cell_ff <= cell_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

endmodule
`default_nettype wire
